// ===== hdl/pts_pkg.sv =====
`timescale 1ns / 1ps

package pts_pkg;

  // Internal working precision: scaled time and its powers are Q.30.
  localparam int WORK_BITS = 30;
  localparam int POW_W     = WORK_BITS + 1;
  localparam int PROD_W    = 64;
  localparam int ACC_W     = 40;

  localparam int FRAC_BITS_DEF = 16;
  localparam int TIME_BITS_DEF = 32;

  localparam int INV_W      = 32;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PROFILE_MODE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_DURATION = 1'd1;

  // Profile codes.
  localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CUBIC   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUINTIC = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SEPTIC  = 2'd3;

  // Polynomial coefficients of the normalized profiles.
  localparam logic signed [ACC_W-1:0] C3_P2 = 40'sd3;
  localparam logic signed [ACC_W-1:0] C3_P3 = -40'sd2;
  localparam logic signed [ACC_W-1:0] C5_P3 = 40'sd10;
  localparam logic signed [ACC_W-1:0] C5_P4 = -40'sd15;
  localparam logic signed [ACC_W-1:0] C5_P5 = 40'sd6;
  localparam logic signed [ACC_W-1:0] C7_P4 = 40'sd35;
  localparam logic signed [ACC_W-1:0] C7_P5 = -40'sd84;
  localparam logic signed [ACC_W-1:0] C7_P6 = 40'sd70;
  localparam logic signed [ACC_W-1:0] C7_P7 = -40'sd20;

  localparam logic [POW_W-1:0] WORK_ONE = POW_W'(1) << WORK_BITS;

  // Per-stage payload of the power chain: p[1] is s, p[k] is s^k.
  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic                    past;
    logic [7:1][POW_W-1:0]   p;
  } pow_t;

endpackage

// ===== hdl/polynomial_time_scaling_unit.sv =====
`timescale 1ns / 1ps
// Point-to-point time scaling. Each transfer on the input channel carries the
// ticks elapsed since the start of a move; the block scales that time by the
// configured reciprocal duration (unsigned Q0.32) to s, clamps s to 1.0 and
// evaluates the selected profile: linear s, cubic 3s^2-2s^3, quintic
// 10s^3-15s^4+6s^5 or septic 35s^4-84s^5+70s^6-20s^7. The result is the
// completed fraction in unsigned Q1.FRAC_BITS, rounded to nearest, together
// with past_end, which is set when the time reached or passed the duration.
// Exactly one result transfer follows every input transfer, in order. The
// datapath is a ten-stage pipeline: one 32x32 multiply for the scaling, a
// clamp stage, six chained 31x31 multiplies that build s^2 through s^7, the
// weighted sum, and the clamp-and-round output register. A new item can be
// taken every cycle while in_stall is low. Empty stages are filled even
// while the output is stalled, so up to ten items can be in flight.
// Configuration must only be written while no item is in flight.

module polynomial_time_scaling_unit #(
  parameter int FRAC_BITS = pts_pkg::FRAC_BITS_DEF,
  parameter int TIME_BITS = pts_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             cfg_we,
  input  logic [pts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pts_pkg::CFG_DATA_W-1:0]   cfg_wdata,

  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [TIME_BITS-1:0]             in_time_ticks,

  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [FRAC_BITS:0]               out_move_fraction,
  output logic                             out_past_end
);

  localparam int NSTG   = 10;
  localparam int POW_W  = pts_pkg::POW_W;
  localparam int PROD_W = pts_pkg::PROD_W;
  localparam int ACC_W  = pts_pkg::ACC_W;
  localparam int INV_W  = pts_pkg::INV_W;
  localparam int MODE_W = pts_pkg::MODE_W;

  // Configuration registers.
  logic [MODE_W-1:0] mode_r;
  logic [INV_W-1:0]  inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= pts_pkg::MODE_LINEAR;
      inv_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pts_pkg::REG_PROFILE_MODE:     mode_r <= cfg_wdata[MODE_W-1:0];
        pts_pkg::REG_INVERSE_DURATION: inv_r  <= cfg_wdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Flow control. A stage loads when it is empty or when the stage after it
  // loads, so bubbles close up while the output is held.
  logic [NSTG:1] v_r;
  logic [NSTG:1] en;

  always_comb begin
    en[NSTG] = !v_r[NSTG] || !out_stall;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Stage 1: scale the time by the reciprocal duration. Time bits from bit 32 up
  // only matter as a nonzero test, since any of them pushes s past 1.0 unless the reciprocal is zero.
  logic [PROD_W-1:0] t_ext;
  logic [PROD_W-1:0] prod_r;
  logic              hi_past_r;
  logic [MODE_W-1:0] mode1_r;

  assign t_ext = PROD_W'(in_time_ticks);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod_r    <= t_ext[31:0] * inv_r;
      hi_past_r <= (|t_ext[PROD_W-1:32]) && (inv_r != '0);
      mode1_r   <= mode_r;
    end
  end

  // Stage 2: clamp to 1.0 and drop to Q.30.
  pts_pkg::pow_t pw_r [2:8];
  pts_pkg::pow_t pw2_nxt;
  logic          past2;

  always_comb begin
    past2        = hi_past_r || (|prod_r[PROD_W-1:32]);
    pw2_nxt      = '0;
    pw2_nxt.mode = mode1_r;
    pw2_nxt.past = past2;
    pw2_nxt.p[1] = past2 ? pts_pkg::WORK_ONE : {1'b0, prod_r[31:2]};
  end

  always_ff @(posedge clk) begin
    if (en[2]) pw_r[2] <= pw2_nxt;
  end

  // Stages 3 to 8: stage k forms s^(k-1) from the previous power and s, each
  // product truncated back to Q.30.
  for (genvar k = 3; k <= 8; k++) begin : g_pow
    logic [2*POW_W-1:0] mul;
    pts_pkg::pow_t      pw_nxt;

    always_comb begin
      mul            = pw_r[k-1].p[k-2] * pw_r[k-1].p[1];
      pw_nxt         = pw_r[k-1];
      pw_nxt.p[k-1]  = mul[pts_pkg::WORK_BITS+POW_W-1:pts_pkg::WORK_BITS];
    end

    always_ff @(posedge clk) begin
      if (en[k]) pw_r[k] <= pw_nxt;
    end
  end

  // Stage 9: weighted sum of the powers for the selected profile.
  logic signed [ACC_W-1:0] e [1:7];
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] acc_r;
  logic                    past9_r;

  always_comb begin
    for (int i = 1; i <= 7; i++) begin
      e[i] = $signed(ACC_W'(pw_r[8].p[i]));
    end
    unique case (pw_r[8].mode)
      pts_pkg::MODE_CUBIC:
        acc_nxt = pts_pkg::C3_P2 * e[2] + pts_pkg::C3_P3 * e[3];
      pts_pkg::MODE_QUINTIC:
        acc_nxt = pts_pkg::C5_P3 * e[3] + pts_pkg::C5_P4 * e[4]
                + pts_pkg::C5_P5 * e[5];
      pts_pkg::MODE_SEPTIC:
        acc_nxt = pts_pkg::C7_P4 * e[4] + pts_pkg::C7_P5 * e[5]
                + pts_pkg::C7_P6 * e[6] + pts_pkg::C7_P7 * e[7];
      default:
        acc_nxt = e[1];
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      acc_r   <= acc_nxt;
      past9_r <= pw_r[8].past;
    end
  end

  // Stage 10: clamp to [0, 1.0] and round to the output precision.
  logic [POW_W-1:0]  clamped;
  logic [FRAC_BITS:0] frac_nxt;

  always_comb begin
    if (acc_r < 0) begin
      clamped = '0;
    end else if (acc_r > $signed(ACC_W'(pts_pkg::WORK_ONE))) begin
      clamped = pts_pkg::WORK_ONE;
    end else begin
      clamped = acc_r[POW_W-1:0];
    end
  end

  if (FRAC_BITS < pts_pkg::WORK_BITS) begin : g_round
    localparam int SH = pts_pkg::WORK_BITS - FRAC_BITS;
    localparam logic [POW_W-1:0] HALF = POW_W'(1) << (SH - 1);
    logic [POW_W-1:0] rounded;
    logic [POW_W-1:0] shifted;

    assign rounded  = clamped + HALF;
    assign shifted  = rounded >> SH;
    assign frac_nxt = shifted[FRAC_BITS:0];
  end else begin : g_noround
    assign frac_nxt = clamped[FRAC_BITS:0];
  end

  always_ff @(posedge clk) begin
    if (en[NSTG]) begin
      out_move_fraction <= frac_nxt;
      out_past_end      <= past9_r;
    end
  end

  assign out_valid = v_r[NSTG];

`ifndef SYNTHESIS
  // Past the end s is exactly 1.0, and every profile sums to exactly 1.0.
  a_past_is_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_past_end |-> out_move_fraction == ((FRAC_BITS+1)'(1) << FRAC_BITS))
    else $error("past_end result is not exactly 1.0");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_move_fraction <= ((FRAC_BITS+1)'(1) << FRAC_BITS))
    else $error("move fraction above 1.0");

  // The input is held off only when every stage holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r) && out_stall)
    else $error("input stalled while the pipeline has room");
`endif

endmodule

// ===== tb/polynomial_time_scaling_unit_tb.sv =====
`timescale 1ns / 1ps

module polynomial_time_scaling_unit_tb;

  localparam int FRAC_BITS   = pts_pkg::FRAC_BITS_DEF;
  localparam int TIME_BITS   = pts_pkg::TIME_BITS_DEF;
  localparam int ROUND_SHIFT = pts_pkg::WORK_BITS - FRAC_BITS;

  // The receiver holds off this long once, which is far beyond the ten
  // pipeline stages, so the block must fill up and stall its input.
  localparam int HOLD_CYCLES = 300;

  // Slowest correct run is roughly 1.6k transfers, each costing the longest
  // sender gap, the longest receiver stall and the pipeline latency, plus the
  // long hold and the drains between phases. The limit leaves ample margin.
  localparam int CYCLE_LIMIT = 400000;

  localparam int RANDOM_PHASES = 16;
  localparam int PHASE_ITEMS   = 100;
  localparam int QUIET_PHASES  = 3;

  // Golden model of the setpoint generator plus the queue of outstanding
  // setpoints. Configuration is mirrored here as it is written.
  class setpoint_scoreboard;
    typedef struct {
      logic [31:0]        ticks;
      logic [FRAC_BITS:0] fraction;
      logic               past_end;
    } setpoint_t;

    logic [pts_pkg::MODE_W-1:0] mode_reg;
    logic [pts_pkg::INV_W-1:0]  inv_reg;
    setpoint_t                  outstanding[$];
    int                         failures;

    function new();
      mode_reg  = pts_pkg::MODE_LINEAR;
      inv_reg   = '0;
      failures  = 0;
    endfunction

    function void set_register(logic [pts_pkg::CFG_IDX_W-1:0] idx,
                               logic [pts_pkg::CFG_DATA_W-1:0] value);
      if (idx == pts_pkg::REG_PROFILE_MODE) begin
        mode_reg = value[pts_pkg::MODE_W-1:0];
      end else if (idx == pts_pkg::REG_INVERSE_DURATION) begin
        inv_reg = value[pts_pkg::INV_W-1:0];
      end
    endfunction

    // Truncating multiply of two Q.30 values.
    function longint q30_mul(longint a, longint b);
      return (a * b) >>> pts_pkg::WORK_BITS;
    endfunction

    function setpoint_t scale_and_shape(logic [TIME_BITS-1:0] ticks);
      setpoint_t   sp;
      logic [63:0] prod;
      longint      s, p2, p3, p4, p5, p6, p7, acc;
      prod = {32'd0, ticks} * {32'd0, inv_reg};
      sp.ticks = ticks;
      sp.past_end = (prod >= 64'h1_0000_0000);
      if (sp.past_end) begin
        prod = 64'h1_0000_0000;
      end
      s  = longint'(prod >> 2);
      p2 = q30_mul(s, s);
      p3 = q30_mul(p2, s);
      p4 = q30_mul(p3, s);
      p5 = q30_mul(p4, s);
      p6 = q30_mul(p5, s);
      p7 = q30_mul(p6, s);
      case (mode_reg)
        pts_pkg::MODE_CUBIC:   acc = 3 * p2 - 2 * p3;
        pts_pkg::MODE_QUINTIC: acc = 10 * p3 - 15 * p4 + 6 * p5;
        pts_pkg::MODE_SEPTIC:  acc = 35 * p4 - 84 * p5 + 70 * p6 - 20 * p7;
        default:               acc = s;
      endcase
      if (acc < 0) begin
        acc = 0;
      end
      if (acc > (longint'(1) << pts_pkg::WORK_BITS)) begin
        acc = longint'(1) << pts_pkg::WORK_BITS;
      end
      acc = (acc + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      sp.fraction = acc[FRAC_BITS:0];
      return sp;
    endfunction

    function void note_time(logic [TIME_BITS-1:0] ticks);
      outstanding.push_back(scale_and_shape(ticks));
    endfunction

    function void check_setpoint(logic [FRAC_BITS:0] fraction, logic past_end);
      setpoint_t sp;
      if (outstanding.size() == 0) begin
        failures++;
        $display("%0t: unexpected result: move_fraction %0d past_end %0b",
                 $time, fraction, past_end);
        return;
      end
      sp = outstanding.pop_front();
      if (fraction !== sp.fraction) begin
        failures++;
        $display("%0t: move_fraction mismatch for ticks %0d: expected %0d, got %0d",
                 $time, sp.ticks, sp.fraction, fraction);
      end
      if (past_end !== sp.past_end) begin
        failures++;
        $display("%0t: past_end mismatch for ticks %0d: expected %0b, got %0b",
                 $time, sp.ticks, sp.past_end, past_end);
      end
    endfunction

    function int pending();
      return outstanding.size();
    endfunction

    function void flag_leftovers();
      if (outstanding.size() != 0) begin
        failures += outstanding.size();
        $display("%0t: %0d results never arrived, oldest for ticks %0d",
                 $time, outstanding.size(), outstanding[0].ticks);
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n         = 1'b0;
  logic                           cfg_we        = 1'b0;
  logic [pts_pkg::CFG_IDX_W-1:0]  cfg_index     = pts_pkg::REG_PROFILE_MODE;
  logic [pts_pkg::CFG_DATA_W-1:0] cfg_wdata     = '0;
  logic                           in_valid      = 1'b0;
  logic                           in_stall;
  logic [TIME_BITS-1:0]           in_time_ticks = '0;
  logic                           out_valid;
  logic                           out_stall     = 1'b0;
  logic [FRAC_BITS:0]             out_move_fraction;
  logic                           out_past_end;

  setpoint_scoreboard sb;

  // Pacing knobs set by the stimulus, some read by the receiver process, and the watchdog's cycle counter.
  bit src_idle_on  = 1'b0;
  bit sink_idle_on = 1'b0;
  bit hold_request = 1'b0;
  int cycle_count  = 0;

  polynomial_time_scaling_unit #(
    .FRAC_BITS(FRAC_BITS),
    .TIME_BITS(TIME_BITS)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_time_ticks     (in_time_ticks),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_move_fraction (out_move_fraction),
    .out_past_end      (out_past_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both monitors sample at the clock edge, before any of this edge's
  // nonblocking updates land, so they see exactly what the block saw.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_time(in_time_ticks);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_setpoint(out_move_fraction, out_past_end);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("polynomial_time_scaling_unit_tb: done, errors");
      $finish;
    end
  end

  // Receiver side. Either a single long hold requested by the stimulus, or
  // random stall bursts while sink idling is enabled. A burst always ends
  // with stall low before the next one can begin, and it is cut short as
  // soon as sink idling is switched off.
  initial begin : sink_pacing
    int span;
    bit held;
    forever begin
      @(posedge clk);
      if (hold_request && !held) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        held = 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        span = $urandom_range(1, 16);
        out_stall <= 1'b1;
        for (int i = 0; i < span && sink_idle_on; i++) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one time value and return once the transfer has happened. Valid
  // stays high afterwards so back-to-back items need no extra assignment.
  task automatic send_time(input logic [TIME_BITS-1:0] ticks);
    int gap;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_time_ticks <= ticks;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering and wait for every outstanding setpoint. Every input makes
  // exactly one result, so once the queue is empty the pipeline is empty.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write both registers on consecutive edges. The mode word may carry junk
  // above its two bits; the block keeps only the low bits.
  task automatic program_profile(input logic [pts_pkg::CFG_DATA_W-1:0] mode_word,
                                 input logic [pts_pkg::CFG_DATA_W-1:0] inv);
    cfg_we    <= 1'b1;
    cfg_index <= pts_pkg::REG_PROFILE_MODE;
    cfg_wdata <= mode_word;
    @(posedge clk);
    cfg_index <= pts_pkg::REG_INVERSE_DURATION;
    cfg_wdata <= inv;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(pts_pkg::REG_PROFILE_MODE, mode_word);
    sb.set_register(pts_pkg::REG_INVERSE_DURATION, inv);
    @(posedge clk);
  endtask

  // Pick a time relative to the move duration: mostly inside the move, some
  // right at its end, some anywhere in the 32-bit range, some near zero.
  function automatic logic [TIME_BITS-1:0] pick_ticks(input longint duration);
    longint t;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: t = longint'($urandom_range(0, 32'(duration)));
      6:                t = duration + longint'($urandom_range(0, 4)) - 2;
      7, 8:             t = longint'($urandom);
      default:          t = longint'($urandom_range(0, 3));
    endcase
    if (t < 0) begin
      t = 0;
    end
    if (t > 64'hFFFF_FFFF) begin
      t = 64'hFFFF_FFFF;
    end
    return t[TIME_BITS-1:0];
  endfunction

  initial begin : stimulus
    logic [pts_pkg::MODE_W-1:0]     mode;
    logic [pts_pkg::CFG_DATA_W-1:0] inv;
    longint                         duration;
    longint                         span;
    bit                             quiet;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration has a zero reciprocal duration: the fraction must
    // stay at zero and past_end low whatever the time.
    send_time('0);
    send_time('1);
    settle();

    // Shortest possible move: one tick still lands just short of the end, and all ones is past it.
    program_profile({30'd0, pts_pkg::MODE_LINEAR}, 32'hFFFF_FFFF);
    send_time(0);
    send_time(1);
    send_time('1);
    settle();

    // A 1000-tick move under every profile, with junk in the upper mode
    // bits. The reciprocal is rounded down, so 1000 ticks lands just short
    // of the end and 1001 ticks is past it.
    for (int m = 0; m < 4; m++) begin
      mode = pts_pkg::MODE_W'(m);
      program_profile({30'($urandom_range(0, 32'h3FFF_FFFF)), mode}, 32'd4294967);
      send_time(0);
      send_time(500);
      send_time(999);
      send_time(1000);
      send_time(1001);
      settle();
    end

    // Random phases. Each phase reprograms the profile and the reciprocal
    // duration, then sends time values spread over that move. The last few
    // phases run with no idling on either side.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      quiet = (phase >= RANDOM_PHASES - QUIET_PHASES);
      src_idle_on  = !quiet && ($urandom_range(0, 3) != 0);
      sink_idle_on = !quiet && ($urandom_range(0, 3) != 0);
      mode = pts_pkg::MODE_W'($urandom_range(0, 3));
      case ($urandom_range(0, 6))
        0: inv = 32'hFFFF_FFFF;
        1: inv = 32'd1;
        2: inv = $urandom;
        default: begin
          span = longint'(1) << $urandom_range(1, 24);
          duration = longint'($urandom_range(1, 32'(span)));
          if ($urandom_range(0, 1) == 0) begin
            inv = 32'((longint'(1) << 32) / duration);
          end else begin
            inv = 32'(((longint'(1) << 32) + duration - 1) / duration);
          end
        end
      endcase
      if (inv == 0) begin
        duration = 64'hFFFF_FFFF;
      end else begin
        duration = ((longint'(1) << 32) + inv - 1) / inv;
      end
      program_profile({30'($urandom_range(0, 32'h3FFF_FFFF)), mode}, inv);

      // One phase starts with the receiver frozen while the sender keeps
      // offering back to back, so the pipeline fills and pushes back.
      if (phase == 4) begin
        src_idle_on  = 1'b0;
        hold_request = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_time(pick_ticks(duration));
      end
      settle();
    end

    repeat (20) @(posedge clk);
    sb.flag_leftovers();
    if (sb.failures == 0) begin
      $display("polynomial_time_scaling_unit_tb: done, clean");
    end else begin
      $display("polynomial_time_scaling_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
